[rtl/remb_pkg.sv]
// shared types and constants of the rgb emboss filter
`timescale 1ns / 1ps

package remb_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int MIN_DIM        = 3;

	localparam int DIM_W = 13;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// luma in q8.16
	localparam int LUMA_W = 24;
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// kernel partial sums and signed total
	localparam int PART_W = LUMA_W + 2;
	localparam int SUM_W  = LUMA_W + 4;
	localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(128 * 65536);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} remb_reg_t;

	// one luma column entering the window
	typedef struct packed {
		logic [LUMA_W-1:0] up;
		logic [LUMA_W-1:0] mid;
		logic [LUMA_W-1:0] luma;
		logic              emit;
		logic              last;
	} remb_col_t;

endpackage

[rtl/rgb_emboss_filter_3x3_unit.sv]
// top level of the rgb emboss filter: register port and pipeline
`timescale 1ns / 1ps

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+----------------------------
// in       | sink      | in_valid / in_stall | red, green, blue
// out      | source    | out_valid/out_stall | emboss_value, frame_last
// config   | apb slave | psel/penable/pready | image_width 0x0, height 0x4
//
// one pixel per clock sustained while out_stall stays low; a result passes from its
// pixel through s1, s2, s3 and s4 into the output register; the line store ram (one read, one
// write-back per pixel) and the three constant-weight multipliers set the pace
// stalls ripple back stage by stage, so bubbles are squeezed out; a pixel
// that makes no result leaves the kernel stage even while the output is stalled
// reset clears counters and valids; the line store needs no clearing pass
// writing a register restarts the frame at row 0, column 0

module rgb_emboss_filter_3x3_unit
	import remb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	// embossed pixel out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  emboss_value,
	output logic        frame_last
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	logic [DIM_W-1:0] width_q, height_q;
	logic             cfg_wr;
	remb_reg_t        reg_sel;
	logic [XW-1:0]    width_last;
	logic [YW-1:0]    height_last;

	logic      col_valid, col_stall;
	remb_col_t col;

	assign pready  = 1'b1;
	assign reg_sel = remb_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	// geometry clamped to 3..max, kept as last column / last row index
	always_comb begin
		if (32'(width_q) > MAX_WIDTH) begin
			width_last = XW'(MAX_WIDTH - 1);
		end else if (32'(width_q) < MIN_DIM) begin
			width_last = XW'(MIN_DIM - 1);
		end else begin
			width_last = XW'(width_q - DIM_W'(1));
		end
		if (32'(height_q) > MAX_HEIGHT) begin
			height_last = YW'(MAX_HEIGHT - 1);
		end else if (32'(height_q) < MIN_DIM) begin
			height_last = YW'(MIN_DIM - 1);
		end else begin
			height_last = YW'(height_q - DIM_W'(1));
		end
	end

	// front end: position, luma, line store read and write-back
	remb_luma_line #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_luma_line (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.width_last (width_last),
		.height_last(height_last),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.col_valid  (col_valid),
		.col_stall  (col_stall),
		.col        (col)
	);

	// back end: window, kernel, clamp, output register
	remb_kernel u_kernel (
		.clk         (clk),
		.arst_n      (arst_n),
		.col_valid   (col_valid),
		.col_stall   (col_stall),
		.col         (col),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.emboss_value(emboss_value),
		.frame_last  (frame_last)
	);

endmodule

[rtl/remb_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module remb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/remb_luma_line.sv]
// raster counters, luma conversion and line store read-modify-write
`timescale 1ns / 1ps

module remb_luma_line
	import remb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [$clog2(MAX_WIDTH)-1:0]  width_last,
	input  logic [$clog2(MAX_HEIGHT)-1:0] height_last,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	output logic                          col_valid,
	input  logic                          col_stall,
	output remb_col_t                     col
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int LINE_W = 2 * LUMA_W;

	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;

	logic              valid_s1;
	logic [7:0]        red_s1, green_s1, blue_s1;
	logic [XW-1:0]     x_s1;
	logic              emit_s1, last_s1;

	logic              valid_s2;
	remb_col_t         col_s2;

	logic              accept, s1_adv, s2_adv;
	logic [LINE_W-1:0] rd_data;
	logic [LUMA_W-1:0] luma;

	assign s2_adv   = !valid_s2 || !col_stall;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign in_stall = !s1_adv;
	assign accept   = in_valid && s1_adv;

	// constant-weight luma, weights sum to one in q0.16
	assign luma = LUMA_W'(red_s1)   * LUMA_W'(W_RED)
	            + LUMA_W'(green_s1) * LUMA_W'(W_GREEN)
	            + LUMA_W'(blue_s1)  * LUMA_W'(W_BLUE);

	// upper half holds row y-2, lower half row y-1
	remb_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (valid_s1 && s2_adv),
		.wr_addr(x_s1),
		.wr_data({rd_data[LUMA_W-1:0], luma}),
		.rd_en  (accept),
		.rd_addr(x_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (restart) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (x_q == width_last) begin
				x_q <= '0;
				y_q <= (y_q == height_last) ? '0 : y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= accept;
			end
			if (s2_adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			x_s1     <= x_q;
			emit_s1  <= (32'(x_q) >= MIN_DIM - 1) && (32'(y_q) >= MIN_DIM - 1);
			last_s1  <= (x_q == width_last) && (y_q == height_last);
		end
		if (valid_s1 && s2_adv) begin
			col_s2.up   <= rd_data[LINE_W-1:LUMA_W];
			col_s2.mid  <= rd_data[LUMA_W-1:0];
			col_s2.luma <= luma;
			col_s2.emit <= emit_s1;
			col_s2.last <= last_s1;
		end
	end

	assign col_valid = valid_s2;
	assign col       = col_s2;

endmodule

[rtl/remb_kernel.sv]
// 3x3 luma window, emboss kernel, bias, clamp and output register
`timescale 1ns / 1ps

module remb_kernel
	import remb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       col_valid,
	output logic       col_stall,
	input  remb_col_t  col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] emboss_value,
	output logic       frame_last
);

	logic [LUMA_W-1:0] win_q [9];
	logic              valid_s3, emit_s3, last_s3;
	logic              valid_s4, emit_s4, last_s4;
	logic [PART_W-1:0] pos_s4, neg_s4;
	logic              out_valid_q, last_q;
	logic [7:0]        value_q;

	logic                    s3_adv, s4_adv, out_adv;
	logic signed [SUM_W-1:0] total;
	logic [7:0]              clamped;

	assign out_adv   = !out_valid_q || !out_stall;
	assign s4_adv    = !valid_s4 || !emit_s4 || out_adv;
	assign s3_adv    = !valid_s3 || s4_adv;
	assign col_stall = !s3_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_adv) begin
				valid_s3 <= col_valid;
			end
			if (s4_adv) begin
				valid_s4 <= valid_s3;
			end
			if (out_adv) begin
				out_valid_q <= valid_s4 && emit_s4;
			end
		end
	end

	// window moves left, new column on the right
	always_ff @(posedge clk) begin
		if (col_valid && s3_adv) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3+0] <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= col.up;
			win_q[5] <= col.mid;
			win_q[8] <= col.luma;
			emit_s3  <= col.emit;
			last_s3  <= col.last;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && s4_adv) begin
			pos_s4  <= PART_W'(win_q[5]) + PART_W'(win_q[7]) + (PART_W'(win_q[8]) << 1);
			neg_s4  <= (PART_W'(win_q[0]) << 1) + PART_W'(win_q[1]) + PART_W'(win_q[3]);
			emit_s4 <= emit_s3;
			last_s4 <= last_s3;
		end
	end

	assign total = $signed(SUM_W'(pos_s4)) - $signed(SUM_W'(neg_s4)) + BIAS;

	// below zero gives 0, at or above 256.0 saturates, else the integer part
	always_comb begin
		if (total < 0) begin
			clamped = 8'd0;
		end else if (total[SUM_W-1:LUMA_W] != '0) begin
			clamped = 8'hff;
		end else begin
			clamped = total[LUMA_W-1:LUMA_W-8];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s4 && emit_s4) begin
			value_q <= clamped;
			last_q  <= last_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign emboss_value = value_q;
	assign frame_last   = last_q;

endmodule

[tb/tb.sv]
// testbench of the rgb emboss filter: directed and random frames against a luma emboss predictor
`timescale 1ns / 1ps

module tb
	import remb_pkg::*;
();

	// predictor constants: q0.16 luma weights, q8.16 bias and ceiling
	localparam int unsigned RED_WEIGHT   = 13933;
	localparam int unsigned GREEN_WEIGHT = 46871;
	localparam int unsigned BLUE_WEIGHT  = 4732;
	localparam longint      Q16_UNIT     = 65536;
	localparam int unsigned MAX_W        = 4096;
	localparam int unsigned MAX_H        = 4096;
	// cycles a pixel may still be in flight once the last result has left
	localparam int          DRAIN_CYCLES = 16;
	localparam int          MAX_PRINTED  = 20;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} emboss_result_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [7:0]  red          = '0;
	logic [7:0]  green        = '0;
	logic [7:0]  blue         = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [7:0]  emboss_value;
	logic        frame_last;

	// idling knobs, percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	// long output hold-off request, picked up by the stall process
	int unsigned hold_len      = 0;
	int unsigned mismatch_count = 0;

	// predictor state
	bit   [23:0] luma_upper  [MAX_W];
	bit   [23:0] luma_middle [MAX_W];
	bit   [23:0] luma_win    [9];
	int unsigned col_pos;
	int unsigned row_pos;
	logic [12:0] cfg_width  = 13'd640;
	logic [12:0] cfg_height = 13'd480;

	emboss_result_t emboss_pending [$];

	rgb_emboss_filter_3x3_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.emboss_value (emboss_value),
		.frame_last   (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(20_000_000);
		$display("** rgb_emboss_filter_3x3_unit: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED) begin
			$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		end
	endtask

	// window and position go back to the top-left corner; line stores keep their data
	function void restart_frame();
		foreach (luma_win[k]) luma_win[k] = '0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	// one accepted pixel: update line stores and window, queue a result at interior positions
	function void predict_emboss(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int unsigned    w_used;
		int unsigned    h_used;
		bit   [23:0]    luma;
		bit   [23:0]    up;
		bit   [23:0]    mid;
		longint         acc;
		emboss_result_t res;
		w_used = (cfg_width < 3) ? 3 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
		h_used = (cfg_height < 3) ? 3 : ((cfg_height > MAX_H) ? MAX_H : cfg_height);
		luma = 24'(r * RED_WEIGHT + g * GREEN_WEIGHT + b * BLUE_WEIGHT);
		up  = luma_upper[col_pos];
		mid = luma_middle[col_pos];
		luma_upper[col_pos]  = mid;
		luma_middle[col_pos] = luma;
		for (int k = 0; k < 3; k++) begin
			luma_win[k*3]     = luma_win[k*3 + 1];
			luma_win[k*3 + 1] = luma_win[k*3 + 2];
		end
		luma_win[2] = up;
		luma_win[5] = mid;
		luma_win[8] = luma;
		if (col_pos >= 2 && row_pos >= 2) begin
			// kernel [-2 -1 0; -1 0 1; 0 1 2] plus the 128 bias, all in q8.16
			acc = -2 * longint'(luma_win[0]) - longint'(luma_win[1]) - longint'(luma_win[3])
				+ longint'(luma_win[5]) + longint'(luma_win[7]) + 2 * longint'(luma_win[8])
				+ 128 * Q16_UNIT;
			if (acc < 0) acc = 0;
			if (acc > 255 * Q16_UNIT) acc = 255 * Q16_UNIT;
			res.value = 8'(acc / Q16_UNIT);
			res.last  = (col_pos == w_used - 1) && (row_pos == h_used - 1);
			emboss_pending.push_back(res);
		end
		col_pos++;
		if (col_pos >= w_used) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h_used) row_pos = 0;
		end
	endfunction

	// output stall: random, or held high for a counted stretch on request
	initial begin : stall_driver
		int unsigned stretch;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				stretch  = hold_len;
				hold_len = 0;
				out_stall <= 1'b1;
				repeat (stretch - 1) @(posedge clk);
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	// result checker: output signals are stable at the falling edge, the transaction
	// completes at the next rising edge
	always @(negedge clk) begin : result_check
		emboss_result_t want;
		if (arst_n) begin
			if ($isunknown(out_valid)) begin
				report_mismatch("out_valid unknown", 0, 0);
			end else if (out_valid && out_stall === 1'b0) begin
				if (emboss_pending.size() == 0) begin
					report_mismatch("result with none pending", emboss_value, -1);
				end else begin
					want = emboss_pending.pop_front();
					if (emboss_value !== want.value)
						report_mismatch("emboss_value", emboss_value, want.value);
					if (frame_last !== want.last)
						report_mismatch("frame_last", frame_last, want.last);
				end
			end
		end
	end

	// one pixel transaction; returns at the edge that takes it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic taken;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		predict_emboss(r, g, b);
	endtask

	// biased toward the extremes so clamping at both ends is hit often
	function automatic logic [7:0] rand_level();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_pixels(input int unsigned count);
		repeat (count) send_pixel(rand_level(), rand_level(), rand_level());
	endtask

	// drop valid, let every pending result come out, then give in-flight pixels time
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (emboss_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input remb_reg_t idx, input logic [12:0] value);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {19'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (rdy !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == REG_IMAGE_WIDTH) cfg_width = value;
		else cfg_height = value;
		restart_frame();
	endtask

	task automatic check_register(input remb_reg_t idx, input logic [12:0] want);
		logic        rdy;
		logic [31:0] data;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy  = pready;
			data = prdata;
			@(posedge clk);
		end while (rdy !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (data[12:0] !== want) report_mismatch(idx.name(), data[12:0], want);
	endtask

	// geometry changes only with the block drained
	task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
		wait_idle();
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
	endtask

	// reset geometry 640 x 480: read back, then the start of the first row
	task automatic test_reset_defaults();
		send_idle_pct = 26;
		stall_pct     = 26;
		check_register(REG_IMAGE_WIDTH, 13'd640);
		check_register(REG_IMAGE_HEIGHT, 13'd480);
		send_random_pixels(32);
	endtask

	// geometry below the minimum clamps to 3 x 3; dark and bright corners drive
	// the sum past both clamp limits, and the second frame follows a wrap
	task automatic test_pixel_extremes();
		logic [7:0] level;
		send_idle_pct = 0;
		stall_pct     = 0;
		set_geometry(13'd0, 13'd2);
		check_register(REG_IMAGE_WIDTH, 13'd0);
		check_register(REG_IMAGE_HEIGHT, 13'd2);
		for (int i = 0; i < 9; i++) begin
			level = (i == 0) ? 8'h00 : 8'hff;
			send_pixel(level, level, level);
		end
		for (int i = 0; i < 9; i++) begin
			level = (i == 0) ? 8'hff : 8'h00;
			send_pixel(level, level, level);
		end
	endtask

	// all-ones width clamps to the widest row; the start of the first row
	// makes no result
	task automatic test_width_clamp();
		send_idle_pct = 0;
		stall_pct     = 0;
		set_geometry(13'h1fff, 13'd3);
		check_register(REG_IMAGE_WIDTH, 13'h1fff);
		send_random_pixels(32);
	endtask

	// all-ones height clamps to the tallest frame, narrow rows keep results
	// coming with frame_last low
	task automatic test_height_clamp();
		send_idle_pct = 0;
		stall_pct     = 0;
		set_geometry(13'd3, 13'h1fff);
		check_register(REG_IMAGE_HEIGHT, 13'h1fff);
		send_random_pixels(48);
	endtask

	// the receiver holds off while pixels keep coming, so the pipe fills and
	// in_stall has to rise
	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct     = 26;
		set_geometry(13'd4, 13'd4);
		hold_len = 300;
		send_random_pixels(64);
	endtask

	// random geometries, whole frames, back-to-back frames and cut-off frames
	// under each idling phase
	task automatic test_random_frames();
		int unsigned send_mix  [4] = '{0, 57, 0, 26};
		int unsigned stall_mix [4] = '{0, 0, 57, 26};
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned count;
		logic [12:0] w_raw;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_mix[p];
			stall_pct     = stall_mix[p];
			sent          = 0;
			while (sent < 70) begin
				w = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
				h = $urandom_range(3, 6);
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: count = w * h;
					6, 7:             count = 2 * w * h;
					default:          count = $urandom_range(1, w * h - 1);
				endcase
				// a width below the minimum behaves as 3
				w_raw = (w == 3 && $urandom_range(3) == 0) ? 13'($urandom_range(2)) : 13'(w);
				set_geometry(w_raw, 13'(h));
				send_random_pixels(count);
				sent += count;
			end
		end
	endtask

	initial begin
		restart_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_pixel_extremes();
		test_width_clamp();
		test_height_clamp();
		test_output_hold();
		test_random_frames();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("** rgb_emboss_filter_3x3_unit: PASSED **");
		end else begin
			$display("** rgb_emboss_filter_3x3_unit: FAILED **");
		end
		$finish;
	end

endmodule

[files.f]
rtl/remb_pkg.sv
rtl/remb_ram.sv
rtl/remb_luma_line.sv
rtl/remb_kernel.sv
rtl/rgb_emboss_filter_3x3_unit.sv
tb/tb.sv
